### rtl/core/spds_pkg.sv
// Package with the constants and helper functions of the small-prime divisibility sieve.
`default_nettype none
package spds_pkg;

    localparam int NUM_FOLDS = 4;
    localparam int NUM_TESTS = 16;

    localparam logic [63:0] SMALL_LIMIT = 64'd152;

    typedef logic [1:0] t_fold_idx;

    // Chunk widths n of the folds, whose moduli are 2^n-1: 60, 56, 36, 44.
    localparam int FOLD_W [NUM_FOLDS] = '{60, 56, 36, 44};

    // Which fold sum each divisibility test reads.
    localparam t_fold_idx TEST_FOLD [NUM_TESTS] = '{
        2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
        2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
        2'd2, 2'd2, 2'd2, 2'd2,
        2'd3, 2'd3
    };

    // Inverse of each prime modulo 2^64, in the order
    // 13 31 41 61 151, 17 29 43 113 127, 19 37 73 109, 23 89.
    localparam logic [63:0] TEST_INV [NUM_TESTS] = '{
        64'h4ec4ec4ec4ec4ec5, 64'hef7bdef7bdef7bdf, 64'h8f9c18f9c18f9c19,
        64'h4fbcda3ac10c9715, 64'h6fe4dfc9bf937f27,
        64'hf0f0f0f0f0f0f0f1, 64'h34f72c234f72c235, 64'h82fa0be82fa0be83,
        64'h90fdbc090fdbc091, 64'h7efdfbf7efdfbf7f,
        64'h86bca1af286bca1b, 64'h14c1bacf914c1bad, 64'h7e3f1f8fc7e3f1f9,
        64'ha6c0964fda6c0965,
        64'hd37a6f4de9bd37a7, 64'hf47e8fd1fa3f47e9
    };

    // floor((2^64-1)/p) for the same primes.
    localparam logic [63:0] TEST_LIM [NUM_TESTS] = '{
        64'h13b13b13b13b13b1, 64'h0842108421084210, 64'h063e7063e7063e70,
        64'h04325c53ef368eb0, 64'h01b2036406c80d90,
        64'h0f0f0f0f0f0f0f0f, 64'h08d3dcb08d3dcb08, 64'h05f417d05f417d05,
        64'h0243f6f0243f6f02, 64'h0204081020408102,
        64'h0d79435e50d79435, 64'h06eb3e45306eb3e4, 64'h0381c0e070381c0e,
        64'h02593f69b02593f6,
        64'h0b21642c8590b216, 64'h02e05c0b81702e05
    };

    // Sum of three n-bit chunks; the top chunk keeps all remaining bits.
    function automatic logic [63:0] fold_sum(input logic [127:0] v, input int n);
        logic [63:0] mask;
        logic [63:0] c0;
        logic [63:0] c1;
        logic [63:0] c2;
        mask = (64'd1 << n) - 64'd1;
        c0   = v[63:0] & mask;
        c1   = 64'(v >> n) & mask;
        c2   = 64'(v >> (2 * n));
        return c0 + c1 + c2;
    endfunction

    // Answer for values up to the small limit: 0, 1 and primes give 1.
    function automatic logic small_answer(input logic [7:0] v);
        logic ans;
        case (v)
            8'd0, 8'd1, 8'd2, 8'd3, 8'd5, 8'd7, 8'd11, 8'd13, 8'd17, 8'd19,
            8'd23, 8'd29, 8'd31, 8'd37, 8'd41, 8'd43, 8'd47, 8'd53, 8'd59,
            8'd61, 8'd67, 8'd71, 8'd73, 8'd79, 8'd83, 8'd89, 8'd97, 8'd101,
            8'd103, 8'd107, 8'd109, 8'd113, 8'd127, 8'd131, 8'd137, 8'd139,
            8'd149, 8'd151: ans = 1'b1;
            default: ans = 1'b0;
        endcase
        return ans;
    endfunction

endpackage
`default_nettype wire

### rtl/core/small_prime_divisibility_sieve_core.sv
// Top level of the small-prime divisibility sieve: a four-stage pipeline.
//
// The core takes one 128-bit number per clock while the output side is not
// stalled and returns one maybe_prime bit per number, in order, from the output
// register. Stage one folds the number into four sums modulo 2^60-1, 2^56-1,
// 2^36-1 and 2^44-1 and resolves numbers of 152 or less from a table; stage two
// forms three 32x32 partial products for each of the sixteen constant-inverse
// multiplies; stage three completes the low 64 bits of each product and compares
// it with its bound; stage four combines the hits into the output register. Each
// stage has its own valid bit and loads whenever it is empty or the stage after it
// moves, so bubbles are squeezed out and a stall holds every item in place.
`default_nettype none
module small_prime_divisibility_sieve_core
    import spds_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [63:0] i_value_low,
    input  wire logic [63:0] i_value_high,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_maybe_prime
);

    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;

    logic        r_s1_vld;
    logic [63:0] r_s1_sum [NUM_FOLDS];
    logic        r_s1_small;
    logic        r_s1_small_ans;

    logic        r_s2_vld;
    logic [63:0] r_s2_pll [NUM_TESTS];
    logic [31:0] r_s2_xa  [NUM_TESTS];
    logic [31:0] r_s2_xb  [NUM_TESTS];
    logic        r_s2_small;
    logic        r_s2_small_ans;

    logic                 r_s3_vld;
    logic [NUM_TESTS-1:0] r_s3_hit;
    logic                 r_s3_small;
    logic                 r_s3_small_ans;

    logic r_out_vld;
    logic r_maybe;

    logic [63:0]          n_s1_sum [NUM_FOLDS];
    logic                 n_s1_small;
    logic                 n_s1_small_ans;
    logic [63:0]          n_s2_pll [NUM_TESTS];
    logic [31:0]          n_s2_xa  [NUM_TESTS];
    logic [31:0]          n_s2_xb  [NUM_TESTS];
    logic [NUM_TESTS-1:0] n_s3_hit;
    logic                 n_maybe;

    // A stage loads when it is empty or its contents move on this cycle.
    assign ld4     = !r_out_vld || i_ready;
    assign ld3     = !r_s3_vld || ld4;
    assign ld2     = !r_s2_vld || ld3;
    assign ld1     = !r_s1_vld || ld2;
    assign o_ready = ld1;

    assign o_valid       = r_out_vld;
    assign o_maybe_prime = r_maybe;

    always_comb begin
        for (int f = 0; f < NUM_FOLDS; f++) begin
            n_s1_sum[f] = fold_sum({i_value_high, i_value_low}, FOLD_W[f]);
        end
        n_s1_small     = (i_value_high == 64'd0) && (i_value_low <= SMALL_LIMIT);
        n_s1_small_ans = small_answer(i_value_low[7:0]);
    end

    // Low 64 bits of s*inv = s_lo*inv_lo + ((s_lo*inv_hi + s_hi*inv_lo) << 32).
    always_comb begin
        for (int t = 0; t < NUM_TESTS; t++) begin
            n_s2_pll[t] = 64'(r_s1_sum[TEST_FOLD[t]][31:0]) * 64'(TEST_INV[t][31:0]);
            n_s2_xa[t]  = 32'(r_s1_sum[TEST_FOLD[t]][31:0] * TEST_INV[t][63:32]);
            n_s2_xb[t]  = 32'(r_s1_sum[TEST_FOLD[t]][63:32] * TEST_INV[t][31:0]);
        end
    end

    always_comb begin
        for (int t = 0; t < NUM_TESTS; t++) begin
            n_s3_hit[t] = (r_s2_pll[t] + {32'(r_s2_xa[t] + r_s2_xb[t]), 32'd0})
                          <= TEST_LIM[t];
        end
    end

    assign n_maybe = r_s3_small ? r_s3_small_ans : (r_s3_hit == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (ld1) begin
                r_s1_vld <= i_valid;
            end
            if (ld2) begin
                r_s2_vld <= r_s1_vld;
            end
            if (ld3) begin
                r_s3_vld <= r_s2_vld;
            end
            if (ld4) begin
                r_out_vld <= r_s3_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_s1_sum       <= n_s1_sum;
            r_s1_small     <= n_s1_small;
            r_s1_small_ans <= n_s1_small_ans;
        end
        if (ld2) begin
            r_s2_pll       <= n_s2_pll;
            r_s2_xa        <= n_s2_xa;
            r_s2_xb        <= n_s2_xb;
            r_s2_small     <= r_s1_small;
            r_s2_small_ans <= r_s1_small_ans;
        end
        if (ld3) begin
            r_s3_hit       <= n_s3_hit;
            r_s3_small     <= r_s2_small;
            r_s3_small_ans <= r_s2_small_ans;
        end
        if (ld4) begin
            r_maybe <= n_maybe;
        end
    end

    // An input transfer always lands in stage one.
    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_s1_vld)
        else $error("input transfer did not reach stage one");

    // A small prime is flagged small and answered as prime.
    a_small_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_value_high == 64'd0 && i_value_low == 64'd151)
        |=> (r_s1_small && r_s1_small_ans))
        else $error("small prime not resolved by the table");

    // A small composite is flagged small and answered as composite.
    a_small_composite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_value_high == 64'd0 && i_value_low == 64'd4)
        |=> (r_s1_small && !r_s1_small_ans))
        else $error("small composite not resolved by the table");

    // A full stage three moves into the output register when that register is free.
    a_s3_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_vld && ld4) |=> r_out_vld)
        else $error("stage three item lost on its way to the output");

endmodule
`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for the small-prime divisibility sieve core.
module tb_top;

    localparam int NUM_CHECKS = 16;
    localparam logic [63:0] SMALL_MAX = 64'd152;

    // Each prime is tested against the fold whose modulus 2^n-1 it divides.
    localparam int CHECK_PRIME [NUM_CHECKS] = '{
        13, 31, 41, 61, 151, 17, 29, 43, 113, 127, 19, 37, 73, 109, 23, 89
    };
    localparam int CHECK_FOLD_N [NUM_CHECKS] = '{
        60, 60, 60, 60, 60, 56, 56, 56, 56, 56, 36, 36, 36, 36, 44, 44
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [63:0] i_value_low = '0;
    logic [63:0] i_value_high = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_maybe_prime;

    logic        tx_idle_on = 1'b1;
    logic        rx_stall_on = 1'b1;
    logic        answer_q[$];
    logic        want_bit;
    int          err_count = 0;

    small_prime_divisibility_sieve_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_value_low   (i_value_low),
        .i_value_high  (i_value_high),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_maybe_prime (o_maybe_prime)
    );

    always #2 i_clk = ~i_clk;

    // Inverse of an odd number modulo 2^64 by Newton iteration; each step
    // doubles the number of correct low bits, starting from three.
    function automatic logic [63:0] inv_mod64(input int p);
        logic [63:0] pp;
        logic [63:0] x;
        pp = 64'(p);
        x  = pp;
        repeat (6) x = x * (64'd2 - pp * x);
        return x;
    endfunction

    // Three n-bit chunks added with 64-bit wrap; the top chunk is unmasked.
    function automatic logic [63:0] fold_mod(input logic [127:0] v, input int n);
        logic [127:0] chunk_mask;
        chunk_mask = (128'd1 << n) - 128'd1;
        return 64'(v & chunk_mask) + 64'((v >> n) & chunk_mask) + 64'(v >> (2 * n));
    endfunction

    function automatic logic small_table(input int v);
        int d;
        if (v < 2) begin
            return 1'b1;
        end
        for (d = 2; d * d <= v; d++) begin
            if (v % d == 0) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic logic sieve_answer(input logic [127:0] v);
        logic [63:0] s;
        logic [63:0] bound;
        int k;
        if (v[127:64] == 64'd0 && v[63:0] <= SMALL_MAX) begin
            return small_table(int'(v[7:0]));
        end
        for (k = 0; k < NUM_CHECKS; k++) begin
            s     = fold_mod(v, CHECK_FOLD_N[k]);
            bound = 64'hffff_ffff_ffff_ffff / 64'(CHECK_PRIME[k]);
            if (s * inv_mod64(CHECK_PRIME[k]) <= bound) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic logic [127:0] rand128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // Presents one number and returns once it has been transferred.
    task automatic send_number(input logic [127:0] v);
        while (tx_idle_on && $urandom_range(99) < 34) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_value_low  <= v[63:0];
        i_value_high <= v[127:64];
        do begin
            @(posedge i_clk);
        end while (o_ready !== 1'b1);
        answer_q.push_back(sieve_answer(v));
    endtask

    always @(posedge i_clk) begin
        i_ready <= !rx_stall_on || ($urandom_range(99) >= 34);
    end

    always @(posedge i_clk) begin
        if (o_valid === 1'b1 && i_ready === 1'b1) begin
            if (answer_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %b",
                         $time, o_maybe_prime);
                err_count++;
            end else begin
                want_bit = answer_q.pop_front();
                if (o_maybe_prime !== want_bit) begin
                    $display("%0t: maybe_prime mismatch: expected %b, actual %b",
                             $time, want_bit, o_maybe_prime);
                    err_count++;
                end
            end
        end
    end

    task automatic test_small_values();
        int vals [12] = '{0, 1, 2, 4, 9, 13, 127, 149, 150, 151, 152, 153};
        foreach (vals[i]) begin
            send_number(128'(vals[i]));
        end
    endtask

    task automatic test_field_extremes();
        send_number({64'd0, 64'hffff_ffff_ffff_ffff});
        send_number({64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff});
        send_number({64'hffff_ffff_ffff_ffff, 64'd0});
        send_number({64'd1, 64'd0});
        send_number(128'd1 << 127);
        send_number((128'd1 << 61) - 128'd1);
    endtask

    // Numbers that hit each fold modulus exactly, and large multiples of primes.
    task automatic test_fold_extremes();
        send_number((128'd1 << 60) - 128'd1);
        send_number((128'd1 << 56) - 128'd1);
        send_number((128'd1 << 36) - 128'd1);
        send_number((128'd1 << 44) - 128'd1);
        send_number((128'd1 << 100) * 128'd151);
        send_number(((128'd1 << 119) + 128'd1) * 128'd89);
    endtask

    task automatic test_random_mix(input int count);
        logic [127:0] v;
        int k;
        repeat (count) begin
            case ($urandom_range(9))
                0, 1, 2: v = rand128();
                3:       v = 128'($urandom_range(200));
                4, 5: begin
                    k = $urandom_range(NUM_CHECKS - 1);
                    v = (rand128() >> $urandom_range(8, 126)) * 128'(CHECK_PRIME[k]);
                end
                6:       v = (rand128() >> $urandom_range(0, 127)) | 128'd1;
                7:       v = (128'd1 << $urandom_range(0, 127)) - 128'($urandom_range(0, 2));
                8:       v = {64'd0, $urandom, $urandom};
                default: v = rand128() & rand128() & rand128();
            endcase
            send_number(v);
        end
    endtask

    // A long stretch with both sides running flat out.
    task automatic test_back_to_back(input int count);
        tx_idle_on  = 1'b0;
        rx_stall_on = 1'b0;
        test_random_mix(count);
        tx_idle_on  = 1'b1;
        rx_stall_on = 1'b1;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_small_values();
        test_field_extremes();
        test_fold_extremes();
        test_random_mix(350);
        test_back_to_back(200);
        test_random_mix(350);
        i_valid <= 1'b0;
        while (answer_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
